### hw/rtl/amftd_pkg.sv
// Shared types, constants and helpers for the motion, free-fall and tap detector.
// Used by amftd_div, accel_motion_freefall_tap_detect_top and the testbench; depends on nothing.
package amftd_pkg;

	// Sample width taken from each axis field, then sign-extended
	localparam int SAMPLE_BITS  = 16;
	localparam int AXIS_W       = 16;
	localparam int SAMPLE_SHIFT = AXIS_W - SAMPLE_BITS;

	// Divider geometry: one quotient bit per cycle
	localparam int DIV_W     = 32;
	localparam int DIV_STEPS = DIV_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register widths
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int MOT_THR_W   = 18;
	localparam int FF_LIMIT_W  = 16;
	localparam int TAP_THR_W   = 17;
	localparam int TIME_W      = 32;

	// Reset values of the configuration registers
	localparam logic [FF_LIMIT_W-1:0] FF_LIMIT_RST    = FF_LIMIT_W'(500);
	localparam logic [TIME_W-1:0]     FF_MIN_TIME_RST = TIME_W'(50);
	localparam logic [TAP_THR_W-1:0]  TAP_THR_RST     = TAP_THR_W'(2000);
	localparam logic [TIME_W-1:0]     TAP_WMIN_RST    = TIME_W'(50);
	localparam logic [TIME_W-1:0]     TAP_WMAX_RST    = TIME_W'(500);

	// Stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 8;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MOTION_ENABLE  = 3'd0,
		REG_MOTION_THR     = 3'd1,
		REG_MOTION_MIN     = 3'd2,
		REG_FF_LIMIT       = 3'd3,
		REG_FF_MIN         = 3'd4,
		REG_TAP_THR        = 3'd5,
		REG_TAP_WIN_MIN    = 3'd6,
		REG_TAP_WIN_MAX    = 3'd7
	} cfg_reg_t;

	// Tap classification codes
	typedef enum logic [1:0] {
		TAP_NONE   = 2'd0,
		TAP_SINGLE = 2'd1,
		TAP_DOUBLE = 2'd2,
		TAP_AFTER  = 2'd3
	} tap_class_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// Take the low SAMPLE_BITS bits of an axis field and sign-extend them
	function automatic logic signed [AXIS_W-1:0] sext_sample(input logic [AXIS_W-1:0] raw);
		logic signed [AXIS_W-1:0] sh;
		sh = signed'(raw << SAMPLE_SHIFT);
		return sh >>> SAMPLE_SHIFT;
	endfunction

endpackage

### hw/rtl/accel_motion_freefall_tap_detect_top.sv
// Accelerometer motion, free-fall and tap detector: sequencer, detectors, stream ports.
// Each accepted item is squared axis by axis on one multiplier, seeded at half the sum of squares,
// refined by two divisions on the shared divider (amftd_div) and registered at the output.
// A sum of squares of 0 or 1 skips both divisions. One item at a time: a new item is accepted only
// after the last result is registered, and a stall on the result side holds the next one off.
// arst_n clears control, detector state and configuration to reset values; no clearing pass.
module accel_motion_freefall_tap_detect_top import amftd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input item: accel_x [15:0], accel_y [31:16], accel_z [47:32], sample_time [79:48]
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	// Result item: motion_event [0], freefall_event [1], tap_event [2], tap_class [4:3]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	// Configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_DIV_A,
		ST_DIV_B,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                  mot_en_q;
	logic [MOT_THR_W-1:0]  mot_thr_q;
	logic [TIME_W-1:0]     mot_min_q;
	logic [FF_LIMIT_W-1:0] ff_limit_q;
	logic [TIME_W-1:0]     ff_min_q;
	logic [TAP_THR_W-1:0]  tap_thr_q;
	logic [TIME_W-1:0]     tap_wmin_q;
	logic [TIME_W-1:0]     tap_wmax_q;

	// Detector state
	logic signed [AXIS_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                     mot_active_q;
	logic [TIME_W-1:0]        mot_start_q;
	logic                     ff_active_q;
	logic [TIME_W-1:0]        ff_start_q;
	logic [TIME_W-1:0]        last_tap_q;
	logic [1:0]               tap_cnt_q;
	logic [TAP_THR_W-1:0]     prev_level_q;

	// Current item and working registers
	logic signed [AXIS_W-1:0] x_q, y_q, z_q;
	logic [TIME_W-1:0]        t_q;
	logic [1:0]               sq_cnt_q;
	logic [DIV_W-1:0]         sumsq_q;
	logic [DIV_W-1:0]         root_q;
	logic                     div_go_q;

	// Output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Divider
	logic [DIV_W-1:0] div_quo;
	div_status_t      div_st;

	amftd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (sumsq_q),
		.divisor  (root_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	logic in_acc;
	logic out_free;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Square one axis per cycle on the shared multiplier
	logic signed [AXIS_W-1:0]   mul_op;
	logic signed [2*AXIS_W-1:0] mul_p;
	always_comb begin
		case (sq_cnt_q)
			2'd0:    mul_op = x_q;
			2'd1:    mul_op = y_q;
			default: mul_op = z_q;
		endcase
		mul_p = mul_op * mul_op;
	end

	// Newton step: average the estimate with the quotient
	logic [DIV_W:0] newton_sum;
	assign newton_sum = {1'b0, root_q} + {1'b0, div_quo};

	// Motion: summed absolute per-axis change from the previous enabled sample
	logic signed [AXIS_W:0] dx, dy, dz;
	logic [AXIS_W:0]        adx, ady, adz;
	logic [MOT_THR_W-1:0]   mot_total;
	logic                   mot_over;
	logic [TIME_W-1:0]      mot_start_eff;
	logic                   mot_ev;
	always_comb begin
		dx = {x_q[AXIS_W-1], x_q} - {prev_x_q[AXIS_W-1], prev_x_q};
		dy = {y_q[AXIS_W-1], y_q} - {prev_y_q[AXIS_W-1], prev_y_q};
		dz = {z_q[AXIS_W-1], z_q} - {prev_z_q[AXIS_W-1], prev_z_q};
		adx = dx[AXIS_W] ? unsigned'(-dx) : unsigned'(dx);
		ady = dy[AXIS_W] ? unsigned'(-dy) : unsigned'(dy);
		adz = dz[AXIS_W] ? unsigned'(-dz) : unsigned'(dz);
		mot_total = MOT_THR_W'(adx) + MOT_THR_W'(ady) + MOT_THR_W'(adz);
		mot_over  = mot_total > mot_thr_q;
		mot_start_eff = mot_active_q ? mot_start_q : t_q;
		mot_ev = mot_en_q && mot_over && ((t_q - mot_start_eff) >= mot_min_q);
	end

	// Free fall: magnitude below the limit
	logic ff_hit;
	logic ff_ev;
	always_comb begin
		ff_hit = root_q < DIV_W'(ff_limit_q);
		ff_ev  = ff_hit && ff_active_q && ((t_q - ff_start_q) >= ff_min_q);
	end

	// Tap: change in L1 magnitude and gap classification
	logic [AXIS_W:0]      ax, ay, az;
	logic [TAP_THR_W-1:0] level;
	logic [TAP_THR_W-1:0] level_delta;
	logic                 tap_hit;
	logic [TIME_W-1:0]    tap_gap;
	logic                 tap_in_win;
	logic [1:0]           tap_cnt_inc;
	logic [1:0]           tap_cnt_nx;
	tap_class_t           tap_cls;
	always_comb begin
		ax = x_q[AXIS_W-1] ? unsigned'(-{1'b1, x_q}) : {1'b0, x_q};
		ay = y_q[AXIS_W-1] ? unsigned'(-{1'b1, y_q}) : {1'b0, y_q};
		az = z_q[AXIS_W-1] ? unsigned'(-{1'b1, z_q}) : {1'b0, z_q};
		level = TAP_THR_W'(ax) + TAP_THR_W'(ay) + TAP_THR_W'(az);
		level_delta = (level >= prev_level_q) ? (level - prev_level_q)
		                                      : (prev_level_q - level);
		tap_hit     = level_delta > tap_thr_q;
		tap_gap     = t_q - last_tap_q;
		tap_in_win  = (tap_gap < tap_wmax_q) && (tap_gap > tap_wmin_q);
		tap_cnt_inc = tap_cnt_q + 2'd1;
		tap_cnt_nx  = tap_cnt_q;
		tap_cls     = TAP_NONE;
		if (tap_hit) begin
			if (tap_in_win) begin
				if (tap_cnt_inc[1] || tap_cnt_inc == 2'd0) begin
					tap_cnt_nx = 2'd0;
					tap_cls    = TAP_DOUBLE;
				end else begin
					tap_cnt_nx = tap_cnt_inc;
					tap_cls    = TAP_AFTER;
				end
			end else begin
				tap_cnt_nx = 2'd1;
				tap_cls    = TAP_SINGLE;
			end
		end
	end

	// Sequencer, detector state, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sq_cnt_q     <= '0;
			div_go_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			mot_en_q     <= 1'b0;
			mot_thr_q    <= '0;
			mot_min_q    <= '0;
			ff_limit_q   <= FF_LIMIT_RST;
			ff_min_q     <= FF_MIN_TIME_RST;
			tap_thr_q    <= TAP_THR_RST;
			tap_wmin_q   <= TAP_WMIN_RST;
			tap_wmax_q   <= TAP_WMAX_RST;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			mot_active_q <= 1'b0;
			mot_start_q  <= '0;
			ff_active_q  <= 1'b0;
			ff_start_q   <= '0;
			last_tap_q   <= '0;
			tap_cnt_q    <= '0;
			prev_level_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// Configuration writes; clearing motion_enable drops all detector state but the tap level
			if (cfg_we) begin
				case (cfg_index)
					REG_MOTION_ENABLE: begin
						mot_en_q <= cfg_data[0];
						if (!cfg_data[0]) begin
							prev_x_q     <= '0;
							prev_y_q     <= '0;
							prev_z_q     <= '0;
							mot_active_q <= 1'b0;
							mot_start_q  <= '0;
							ff_active_q  <= 1'b0;
							ff_start_q   <= '0;
							last_tap_q   <= '0;
							tap_cnt_q    <= '0;
						end
					end
					REG_MOTION_THR:  mot_thr_q  <= cfg_data[MOT_THR_W-1:0];
					REG_MOTION_MIN:  mot_min_q  <= cfg_data[TIME_W-1:0];
					REG_FF_LIMIT:    ff_limit_q <= cfg_data[FF_LIMIT_W-1:0];
					REG_FF_MIN:      ff_min_q   <= cfg_data[TIME_W-1:0];
					REG_TAP_THR:     tap_thr_q  <= cfg_data[TAP_THR_W-1:0];
					REG_TAP_WIN_MIN: tap_wmin_q <= cfg_data[TIME_W-1:0];
					REG_TAP_WIN_MAX: tap_wmax_q <= cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sq_cnt_q <= '0;
						state_q  <= ST_SQ;
					end
				end
				// Accumulate the three squares
				ST_SQ: begin
					sq_cnt_q <= sq_cnt_q + 2'd1;
					if (sq_cnt_q == 2'd2) begin
						state_q <= ST_ROOT;
					end
				end
				// Zero and unit vectors are their own root; otherwise seed at half
				ST_ROOT: begin
					if (sumsq_q[DIV_W-1:1] == '0) begin
						state_q <= ST_DONE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIV_A;
					end
				end
				ST_DIV_A: begin
					if (div_st.done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIV_B;
					end
				end
				ST_DIV_B: begin
					if (div_st.done) begin
						state_q <= ST_DONE;
					end
				end
				// Publish the result and advance detector state
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {3'b000, tap_cls, tap_hit, ff_ev, mot_ev};
						if (mot_en_q) begin
							prev_x_q <= x_q;
							prev_y_q <= y_q;
							prev_z_q <= z_q;
							if (mot_over) begin
								mot_active_q <= 1'b1;
								mot_start_q  <= mot_start_eff;
							end else begin
								mot_active_q <= 1'b0;
							end
						end
						if (ff_hit) begin
							if (!ff_active_q) begin
								ff_active_q <= 1'b1;
								ff_start_q  <= t_q;
							end
						end else begin
							ff_active_q <= 1'b0;
						end
						if (tap_hit) begin
							last_tap_q <= t_q;
						end
						tap_cnt_q    <= tap_cnt_nx;
						prev_level_q <= level;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: item capture, square sum and root estimate
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q     <= sext_sample(s_axis_tdata[AXIS_W-1:0]);
			y_q     <= sext_sample(s_axis_tdata[2*AXIS_W-1:AXIS_W]);
			z_q     <= sext_sample(s_axis_tdata[3*AXIS_W-1:2*AXIS_W]);
			t_q     <= s_axis_tdata[3*AXIS_W+TIME_W-1:3*AXIS_W];
			sumsq_q <= '0;
		end else if (state_q == ST_SQ) begin
			sumsq_q <= sumsq_q + unsigned'(mul_p);
		end
		if (state_q == ST_ROOT) begin
			if (sumsq_q[DIV_W-1:1] == '0) begin
				root_q <= sumsq_q;
			end else begin
				root_q <= sumsq_q >> 1;
			end
		end else if ((state_q == ST_DIV_A || state_q == ST_DIV_B) && div_st.done) begin
			root_q <= newton_sum[DIV_W:1];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// An accepted item always starts the squaring pass
	a_accept_to_sq: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SQ))
		else $error("accepted item did not start squaring");

	// Divider completion only lands in a division state
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV_A || state_q == ST_DIV_B))
		else $error("divider finished outside a division state");

	// Divider is never restarted while it runs
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_st.busy)
		else $error("divider restarted while busy");

	// Tap class is zero whenever no tap is reported
	a_tap_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q[2]) |-> (out_data_q[4:3] == TAP_NONE))
		else $error("tap class set without tap event");

	// Tap counter only ever holds zero or one
	a_tap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		!tap_cnt_q[1])
		else $error("tap counter out of range");

endmodule

### hw/rtl/amftd_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the root refinement.
// Depends on amftd_pkg for widths and the status struct.
module amftd_div import amftd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output div_status_t      status
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_nx;
	logic           fits;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// Control: run DIV_STEPS steps after start, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### dv/accel_motion_freefall_tap_detect_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for accel_motion_freefall_tap_detect_top: streams samples, predicts
// the motion, free-fall and tap flags per sample and checks every result item in order.
// Depends on amftd_pkg and the top-level RTL only.
module accel_motion_freefall_tap_detect_top_test;
	import amftd_pkg::*;

	// Expected flags of one sample
	typedef struct packed {
		logic       motion;
		logic       freefall;
		logic       tap;
		tap_class_t cls;
	} det_result_t;

	// Kinds of sample sequences in the random part
	typedef enum int {
		G_REST,
		G_FALL,
		G_SHAKE,
		G_TAP,
		G_NOISE,
		G_WRAP
	} gesture_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// accel_x [15:0], accel_y [31:16], accel_z [47:32], sample_time [79:48]
	logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// motion_event [0], freefall_event [1], tap_event [2], tap_class [4:3], zeros [7:5]
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// Register mirror
	logic                   cf_mot_en;
	logic [MOT_THR_W-1:0]   cf_mot_thr;
	logic [TIME_W-1:0]      cf_mot_min;
	logic [FF_LIMIT_W-1:0]  cf_ff_limit;
	logic [TIME_W-1:0]      cf_ff_min;
	logic [TAP_THR_W-1:0]   cf_tap_thr;
	logic [TIME_W-1:0]      cf_wmin;
	logic [TIME_W-1:0]      cf_wmax;

	// Detector state mirror
	int                     last_x, last_y, last_z;
	logic                   mot_run;
	logic [TIME_W-1:0]      mot_t0;
	logic                   fall_run;
	logic [TIME_W-1:0]      fall_t0;
	logic [TIME_W-1:0]      tap_t_last;
	logic [1:0]             tap_cnt;
	logic [TAP_THR_W-1:0]   tap_lvl_last;

	det_result_t            flags_due[$];
	logic [TIME_W-1:0]      ms_clock = '0;
	bit                     bursts_on = 1'b0;
	int                     errors = 0;
	int                     sample_count = 0;
	int                     result_count = 0;
	int                     motion_hits = 0;
	int                     fall_hits = 0;
	int                     tap_hits[4] = '{0, 0, 0, 0};

	accel_motion_freefall_tap_detect_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned absval(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Integer root estimate: two Newton steps from s/2
	function automatic longint unsigned newton_mag(longint unsigned s);
		longint unsigned a, b;
		if (s < 2)
			return s;
		a = s / 2;
		b = (a + s / a) / 2;
		return (b + s / b) / 2;
	endfunction

	function automatic void clear_detectors();
		last_x     = 0;
		last_y     = 0;
		last_z     = 0;
		mot_run    = 1'b0;
		mot_t0     = '0;
		fall_run   = 1'b0;
		fall_t0    = '0;
		tap_t_last = '0;
		tap_cnt    = '0;
	endfunction

	function automatic void reset_mirror();
		cf_mot_en    = 1'b0;
		cf_mot_thr   = '0;
		cf_mot_min   = '0;
		cf_ff_limit  = FF_LIMIT_RST;
		cf_ff_min    = FF_MIN_TIME_RST;
		cf_tap_thr   = TAP_THR_RST;
		cf_wmin      = TAP_WMIN_RST;
		cf_wmax      = TAP_WMAX_RST;
		tap_lvl_last = '0;
		clear_detectors();
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_MOTION_ENABLE: begin
				cf_mot_en = v[0];
				if (!v[0])
					clear_detectors();
			end
			REG_MOTION_THR:  cf_mot_thr  = v[MOT_THR_W-1:0];
			REG_MOTION_MIN:  cf_mot_min  = v;
			REG_FF_LIMIT:    cf_ff_limit = v[FF_LIMIT_W-1:0];
			REG_FF_MIN:      cf_ff_min   = v;
			REG_TAP_THR:     cf_tap_thr  = v[TAP_THR_W-1:0];
			REG_TAP_WIN_MIN: cf_wmin     = v;
			REG_TAP_WIN_MAX: cf_wmax     = v;
			default: ;
		endcase
	endfunction

	// Advance the detector mirror by one sample and return its flags
	function automatic det_result_t detect_sample(logic [15:0] rx, logic [15:0] ry,
			logic [15:0] rz, logic [TIME_W-1:0] t);
		det_result_t     r;
		int              sx, sy, sz;
		int unsigned     swing, level, delta;
		longint unsigned energy;
		logic [TIME_W-1:0] gap;
		sx = $signed(rx);
		sy = $signed(ry);
		sz = $signed(rz);
		r = '0;
		r.cls = TAP_NONE;

		// motion: summed axis change against the previous enabled sample
		if (cf_mot_en) begin
			swing = absval(sx - last_x) + absval(sy - last_y) + absval(sz - last_z);
			if (swing > cf_mot_thr) begin
				if (!mot_run) begin
					mot_t0  = t;
					mot_run = 1'b1;
				end
				gap = t - mot_t0;
				if (gap >= cf_mot_min)
					r.motion = 1'b1;
			end else begin
				mot_run = 1'b0;
			end
			last_x = sx;
			last_y = sy;
			last_z = sz;
		end

		// free fall: first low sample only records the start time
		energy = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
		if (newton_mag(energy) < cf_ff_limit) begin
			if (!fall_run) begin
				fall_t0  = t;
				fall_run = 1'b1;
			end else begin
				gap = t - fall_t0;
				if (gap >= cf_ff_min)
					r.freefall = 1'b1;
			end
		end else begin
			fall_run = 1'b0;
		end

		// tap: step in L1 level, classified by gap from the previous tap
		level = absval(sx) + absval(sy) + absval(sz);
		delta = (level >= tap_lvl_last) ? level - tap_lvl_last : tap_lvl_last - level;
		if (delta > cf_tap_thr) begin
			gap = t - tap_t_last;
			r.tap = 1'b1;
			if (gap < cf_wmax && gap > cf_wmin) begin
				tap_cnt = tap_cnt + 2'd1;
				if (tap_cnt >= 2'd2 || tap_cnt == 2'd0) begin
					tap_cnt = 2'd0;
					r.cls   = TAP_DOUBLE;
				end else begin
					r.cls = TAP_AFTER;
				end
			end else begin
				tap_cnt = 2'd1;
				r.cls   = TAP_SINGLE;
			end
			tap_t_last = t;
		end
		tap_lvl_last = level[TAP_THR_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Send one sample; gaps come in random bursts when enabled
	task automatic send_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [TIME_W-1:0] ts);
		@(negedge clk);
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ts, az, ay, ax};
		do @(posedge clk); while (!s_axis_tready);
		flags_due.push_back(detect_sample(ax, ay, az, ts));
		sample_count++;
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (flags_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		apply_reg(idx, v);
	endtask

	// ---------------------------------------------------------------- result check

	function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
		$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		errors++;
	endfunction

	task automatic check_result(logic [OUT_DATA_W-1:0] d);
		det_result_t e;
		result_count++;
		if (flags_due.size() == 0) begin
			$display("%0t: result %h with no sample outstanding", $time, d);
			errors++;
			return;
		end
		e = flags_due.pop_front();
		if (d[0] !== e.motion)
			flag_mismatch("motion_event", e.motion, d[0]);
		if (d[1] !== e.freefall)
			flag_mismatch("freefall_event", e.freefall, d[1]);
		if (d[2] !== e.tap)
			flag_mismatch("tap_event", e.tap, d[2]);
		if (d[4:3] !== e.cls)
			flag_mismatch("tap_class", e.cls, d[4:3]);
		if (d[7:5] !== 3'b000)
			flag_mismatch("padding", 0, d[7:5]);
		motion_hits += e.motion;
		fall_hits   += e.freefall;
		tap_hits[int'(e.cls)]++;
	endtask

	// Sample results at the rising edge, move ready at the falling edge
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic int noise(int amp);
		return int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	task automatic emit(int ax, int ay, int az, logic [TIME_W-1:0] dt);
		ms_clock += dt;
		send_item(16'(ax), 16'(ay), 16'(az), ms_clock);
	endtask

	// Gap between taps, aimed at the edges of the double-tap window
	function automatic logic [TIME_W-1:0] pick_gap();
		case ($urandom_range(0, 5))
			0:       return cf_wmin;
			1:       return cf_wmin + 1;
			2:       return cf_wmax - 1;
			3:       return cf_wmax;
			4:       return cf_wmin + $urandom_range(0, 600);
			default: return $urandom_range(1, 1000);
		endcase
	endfunction

	task automatic random_config(bit wild);
		logic [TIME_W-1:0] lo;
		if (wild) begin
			for (int i = 0; i < 8; i++)
				write_reg(cfg_reg_t'(i), $urandom());
		end else begin
			write_reg(REG_MOTION_ENABLE, 32'($urandom_range(0, 4) != 0));
			write_reg(REG_MOTION_THR, $urandom_range(0, 30000));
			write_reg(REG_MOTION_MIN, $urandom_range(0, 120));
			write_reg(REG_FF_LIMIT, $urandom_range(50, 20000));
			write_reg(REG_FF_MIN, $urandom_range(0, 120));
			write_reg(REG_TAP_THR, $urandom_range(300, 25000));
			lo = $urandom_range(0, 150);
			write_reg(REG_TAP_WIN_MIN, lo);
			write_reg(REG_TAP_WIN_MAX, lo + $urandom_range(0, 600));
		end
	endtask

	// Mostly well-formed sequences: rest, free fall, shaking, tap trains, timestamp wrap; some noise
	task automatic run_gestures(int count);
		int       sent, n, amp;
		bit       hi;
		gesture_t g;
		sent = 0;
		while (sent < count) begin
			g = gesture_t'($urandom_range(0, 5));
			n = $urandom_range(3, 10);
			case (g)
				G_REST:
					for (int i = 0; i < n; i++)
						emit(noise(40), noise(40), 16384 + noise(40), $urandom_range(5, 20));
				G_FALL: begin
					// keep the sum of squares small enough for the current limit
					amp = (cf_ff_limit < 1000) ? 30 : (cf_ff_limit < 5000) ? 90 :
						(cf_ff_limit < 20000) ? 180 : 400;
					for (int i = 0; i < n; i++)
						emit(noise(amp), noise(amp), noise(amp), $urandom_range(1, 40));
				end
				G_SHAKE:
					for (int i = 0; i < n; i++)
						emit(noise(20000), noise(20000), noise(20000), $urandom_range(0, 30));
				G_TAP: begin
					amp = (cf_tap_thr > 29000) ? 32767 :
						int'(cf_tap_thr) + 1 + int'($urandom_range(0, 3000));
					hi = 1'b0;
					for (int i = 0; i < n; i++) begin
						hi = !hi;
						emit(hi ? amp : noise(20), noise(20), 16384 + noise(20), pick_gap());
					end
				end
				G_NOISE: begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						send_item(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
							16'($urandom_range(0, 65535)), $urandom());
				end
				default: begin
					// run the timestamp across the 32-bit wrap
					ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
					for (int i = 0; i < n; i++)
						emit(noise(40), noise(40), 16384 + noise(40), $urandom_range(5, 40));
				end
			endcase
			sent += n;
		end
	endtask

	// ---------------------------------------------------------------- tests

	// Reset values: zero and unit vectors, full-scale samples, tap classes
	task automatic test_reset_defaults();
		send_item(16'h0000, 16'h0000, 16'h0000, 32'd0);
		send_item(16'h0001, 16'h0000, 16'h0000, 32'd60);
		send_item(16'h0000, 16'hFFFF, 16'h0000, 32'd61);
		send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd100);
		send_item(16'h8000, 16'h8000, 16'h8000, 32'd300);
		send_item(16'h0000, 16'h0000, 16'h0000, 32'd400);
		send_item(16'h7FFF, 16'h8000, 16'h0000, 32'd401);
		send_item(16'h0000, 16'h0000, 16'h0001, 32'd1000);
		send_item(16'h8000, 16'h0000, 16'h7FFF, 32'd1200);
		send_item(16'h0000, 16'h0000, 16'h0000, 32'd1300);
		send_item(16'h7FFF, 16'h0000, 16'h0000, 32'd1400);
	endtask

	// Motion onset, threshold ceiling, minimum time and the clear on disable
	task automatic test_motion();
		wait_idle();
		write_reg(REG_MOTION_ENABLE, 32'd1);
		write_reg(REG_MOTION_THR, 32'd0);
		write_reg(REG_MOTION_MIN, 32'd0);
		send_item(16'd100, 16'h0000, 16'h0000, 32'd2000);
		send_item(16'd100, 16'h0000, 16'h0000, 32'd2001);
		send_item(16'h8000, 16'h7FFF, 16'h8000, 32'd2002);
		wait_idle();
		write_reg(REG_MOTION_THR, 32'hFFFF_FFFF);
		send_item(16'h7FFF, 16'h8000, 16'h7FFF, 32'd2003);
		wait_idle();
		write_reg(REG_MOTION_THR, 32'd1000);
		write_reg(REG_MOTION_MIN, 32'd20);
		send_item(16'd5000, 16'h0000, 16'h0000, 32'd2100);
		send_item(-16'sd5000, 16'h0000, 16'h0000, 32'd2110);
		send_item(16'd5000, 16'h0000, 16'h0000, 32'd2120);
		send_item(16'd5000, 16'h0000, 16'h0000, 32'd2130);
		wait_idle();
		// bit 0 low disables and clears all detector state but the tap level
		write_reg(REG_MOTION_ENABLE, 32'hFFFF_FFFE);
		send_item(-16'sd5000, 16'h0000, 16'h0000, 32'd2140);
		wait_idle();
		write_reg(REG_MOTION_ENABLE, 32'd1);
		send_item(-16'sd5000, 16'h0000, 16'h0000, 32'd2150);
	endtask

	// All registers at zero, then with motion enabled, then all at their maximum
	task automatic test_register_extremes();
		wait_idle();
		for (int i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), 32'd0);
		run_gestures(20);
		wait_idle();
		write_reg(REG_MOTION_ENABLE, 32'd1);
		run_gestures(20);
		wait_idle();
		for (int i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), 32'hFFFF_FFFF);
		run_gestures(40);
	endtask

	// Random settings; the sender holds off mid-phase until the block drains
	task automatic test_random_phases();
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			bursts_on = (p != 3);
			random_config(p == 2);
			run_gestures(70);
			wait_idle();
			run_gestures(70);
		end
	endtask

	// Back-to-back traffic with no gaps or stalls
	task automatic test_quiet_tail();
		wait_idle();
		bursts_on = 1'b0;
		random_config(1'b0);
		run_gestures(120);
	endtask

	initial begin
		reset_mirror();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		bursts_on = 1'b1;
		test_reset_defaults();
		test_motion();
		test_register_extremes();
		test_random_phases();
		test_quiet_tail();
		wait_idle();
		repeat (100) @(posedge clk);
		$display("run: %0d samples sent, %0d results checked, %0d motion and %0d free-fall events",
			sample_count, result_count, motion_hits, fall_hits);
		$display("run: taps single %0d, double %0d, after double %0d; %0d mismatches",
			tap_hits[TAP_SINGLE], tap_hits[TAP_DOUBLE], tap_hits[TAP_AFTER], errors);
		if (errors == 0 && flags_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#(20_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule

### accel_motion_freefall_tap_detect_top.f
hw/rtl/amftd_pkg.sv
hw/rtl/amftd_div.sv
hw/rtl/accel_motion_freefall_tap_detect_top.sv
dv/accel_motion_freefall_tap_detect_top_test.sv
